// ===== rtl/wsb_pkg.sv =====
// wsb_pkg: shared types, codes and reset values of the wheel speed balancer
`timescale 1ns / 1ps

package wsb_pkg;

   localparam int unsigned WheelCount = 2;

   localparam logic [1:0] CMD_RIGHT   = 2'd0;
   localparam logic [1:0] CMD_LEFT    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [1:0] CORR_NONE     = 2'd0;
   localparam logic [1:0] CORR_LEFT_UP  = 2'd1;
   localparam logic [1:0] CORR_RIGHT_UP = 2'd2;

   localparam logic [2:0] CSR_ENABLE        = 3'd0;
   localparam logic [2:0] CSR_PERIOD_TICKS  = 3'd1;
   localparam logic [2:0] CSR_WIDTH_INITIAL = 3'd2;
   localparam logic [2:0] CSR_WIDTH_MIN     = 3'd3;
   localparam logic [2:0] CSR_WIDTH_MAX     = 3'd4;

   localparam logic        RST_ENABLE        = 1'b1;
   localparam logic [15:0] RST_PERIOD_TICKS  = 16'd999;
   localparam logic [15:0] RST_WIDTH_INITIAL = 16'd750;
   localparam logic [15:0] RST_WIDTH_MIN     = 16'd700;
   localparam logic [15:0] RST_WIDTH_MAX     = 16'd850;

   typedef enum logic [1:0] {
      ADJ_NONE  = 2'd0,
      ADJ_RAISE = 2'd1,
      ADJ_LOWER = 2'd2
   } adj_op_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] period_ticks;
      logic [15:0] width_initial;
      logic [15:0] width_min;
      logic [15:0] width_max;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] period_index;
      logic [15:0] timer_value;
   } req_item_type;

   typedef struct packed {
      logic [15:0] right_width;
      logic [15:0] left_width;
      logic [31:0] right_period;
      logic [31:0] left_period;
      logic [1:0]  correction;
   } rsp_item_type;

endpackage

// ===== rtl/wheel_speed_balancer.sv =====
// wheel_speed_balancer: encoder period capture and pwm width balancing, top level
// the request is held in the input register and its result in the output register, which drives rsp_valid
// throughput: one item per cycle, sustained as long as results are taken
// the capture phase, periods and widths update in one pass between the two registers
// reset is synchronous and active high: both wheels await a start mark, periods read zero,
// widths load 750 and the configuration registers take their reset values
`timescale 1ns / 1ps

module wheel_speed_balancer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wsb_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wsb_pkg::rsp_item_type rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   wsb_pkg::cfg_type      cfg;
   wsb_pkg::req_item_type in_item_ff;
   wsb_pkg::rsp_item_type out_item_ff;
   wsb_pkg::rsp_item_type out_item_in;
   logic                  in_vld_ff;
   logic                  in_vld_in;
   logic                  out_vld_ff;
   logic                  adv;
   logic                  fire;

   logic        second_edge_ff    [wsb_pkg::WheelCount];
   logic        second_edge_in    [wsb_pkg::WheelCount];
   logic        awaiting_start_ff [wsb_pkg::WheelCount];
   logic        awaiting_start_in [wsb_pkg::WheelCount];
   logic [31:0] start_index_ff    [wsb_pkg::WheelCount];
   logic [31:0] start_index_in    [wsb_pkg::WheelCount];
   logic [15:0] start_timer_ff    [wsb_pkg::WheelCount];
   logic [15:0] start_timer_in    [wsb_pkg::WheelCount];
   logic [31:0] period_ff         [wsb_pkg::WheelCount];
   logic [31:0] period_in         [wsb_pkg::WheelCount];
   logic [15:0] width_ff          [wsb_pkg::WheelCount];
   logic [15:0] width_in          [wsb_pkg::WheelCount];
   logic [15:0] width_adj         [wsb_pkg::WheelCount];

   wsb_pkg::adj_op_type adj_op [wsb_pkg::WheelCount];
   logic                wheel;
   logic                restart;
   logic [31:0]         calc_period;
   logic                calc_forward;
   logic [31:0]         left_new;
   logic [1:0]          corr;

   wsb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake and stage control
   assign adv       = !out_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && adv;
   assign req_ready = !in_vld_ff || adv;
   assign in_vld_in = (req_valid && req_ready) ? 1'b1 : (adv ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (adv) out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_data;
      if (fire) out_item_ff <= out_item_in;
   end

   assign wheel   = in_item_ff.cmd[0];
   assign restart = (in_item_ff.cmd == wsb_pkg::CMD_RESTART);

   wsb_period_calc u_period_calc (
      .period_index (in_item_ff.period_index),
      .timer_value  (in_item_ff.timer_value),
      .start_index  (start_index_ff[wheel]),
      .start_timer  (start_timer_ff[wheel]),
      .period_ticks (cfg.period_ticks),
      .period       (calc_period),
      .forward      (calc_forward)
   );

   // capture phase and comparison
   always_comb begin
      for (int i = 0; i < wsb_pkg::WheelCount; i++) begin
         second_edge_in[i]    = second_edge_ff[i];
         awaiting_start_in[i] = awaiting_start_ff[i];
         start_index_in[i]    = start_index_ff[i];
         start_timer_in[i]    = start_timer_ff[i];
         period_in[i]         = period_ff[i];
         adj_op[i]            = wsb_pkg::ADJ_NONE;
      end
      corr     = wsb_pkg::CORR_NONE;
      left_new = calc_forward ? calc_period : period_ff[1];
      if (restart) begin
         for (int i = 0; i < wsb_pkg::WheelCount; i++) begin
            second_edge_in[i]    = 1'b0;
            awaiting_start_in[i] = 1'b1;
            start_index_in[i]    = 32'd0;
            start_timer_in[i]    = 16'd0;
         end
      end else if (((in_item_ff.cmd == wsb_pkg::CMD_RIGHT) ||
                    (in_item_ff.cmd == wsb_pkg::CMD_LEFT)) && cfg.enable) begin
         if (second_edge_ff[wheel]) begin
            second_edge_in[wheel] = 1'b0;
         end else begin
            second_edge_in[wheel] = 1'b1;
            if (awaiting_start_ff[wheel]) begin
               start_index_in[wheel]    = in_item_ff.period_index;
               start_timer_in[wheel]    = in_item_ff.timer_value;
               awaiting_start_in[wheel] = 1'b0;
            end else begin
               awaiting_start_in[wheel] = 1'b1;
               if (calc_forward) period_in[wheel] = calc_period;
               if (wheel) begin
                  if (left_new > period_ff[0]) begin
                     adj_op[1] = wsb_pkg::ADJ_RAISE;
                     adj_op[0] = wsb_pkg::ADJ_LOWER;
                     corr      = wsb_pkg::CORR_LEFT_UP;
                  end else if (left_new < period_ff[0]) begin
                     adj_op[0] = wsb_pkg::ADJ_RAISE;
                     adj_op[1] = wsb_pkg::ADJ_LOWER;
                     corr      = wsb_pkg::CORR_RIGHT_UP;
                  end
               end
            end
         end
      end
   end

   for (genvar g = 0; g < wsb_pkg::WheelCount; g++) begin : g_adjust
      wsb_width_adjust u_width_adjust (
         .op         (adj_op[g]),
         .width      (width_ff[g]),
         .width_min  (cfg.width_min),
         .width_max  (cfg.width_max),
         .width_next (width_adj[g])
      );
   end

   always_comb begin
      for (int i = 0; i < wsb_pkg::WheelCount; i++) begin
         width_in[i] = restart ? cfg.width_initial : width_adj[i];
      end
   end

   always_comb begin
      out_item_in.right_width  = width_in[0];
      out_item_in.left_width   = width_in[1];
      out_item_in.right_period = period_in[0];
      out_item_in.left_period  = period_in[1];
      out_item_in.correction   = corr;
   end

   // wheel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wsb_pkg::WheelCount; i++) begin
            second_edge_ff[i]    <= 1'b0;
            awaiting_start_ff[i] <= 1'b1;
            start_index_ff[i]    <= 32'd0;
            start_timer_ff[i]    <= 16'd0;
            period_ff[i]         <= 32'd0;
            width_ff[i]          <= wsb_pkg::RST_WIDTH_INITIAL;
         end
      end else if (fire) begin
         for (int i = 0; i < wsb_pkg::WheelCount; i++) begin
            second_edge_ff[i]    <= second_edge_in[i];
            awaiting_start_ff[i] <= awaiting_start_in[i];
            start_index_ff[i]    <= start_index_in[i];
            start_timer_ff[i]    <= start_timer_in[i];
            period_ff[i]         <= period_in[i];
            width_ff[i]          <= width_in[i];
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_item_ff;

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv) |=> (in_vld_ff && $stable(in_item_ff)))
      else $error("input stage lost an item while stalled");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(width_ff[0]) && $stable(width_ff[1]) &&
                 $stable(period_ff[0]) && $stable(period_ff[1])))
      else $error("wheel state changed without a stage transfer");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_vld_ff)
      else $error("processed item did not reach the result register");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && out_vld_ff && !rsp_ready))
      else $error("request side stalled with room available");

   a_corr_left: assert property (@(posedge clock) disable iff (reset)
      (fire && (corr != wsb_pkg::CORR_NONE)) |-> (in_item_ff.cmd == wsb_pkg::CMD_LEFT))
      else $error("correction reported for an item other than a left edge");

endmodule

// ===== rtl/wsb_csr.sv =====
// wsb_csr: configuration registers with their reset values
`timescale 1ns / 1ps

module wsb_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output wsb_pkg::cfg_type cfg
);

   wsb_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= wsb_pkg::RST_ENABLE;
         cfg_ff.period_ticks  <= wsb_pkg::RST_PERIOD_TICKS;
         cfg_ff.width_initial <= wsb_pkg::RST_WIDTH_INITIAL;
         cfg_ff.width_min     <= wsb_pkg::RST_WIDTH_MIN;
         cfg_ff.width_max     <= wsb_pkg::RST_WIDTH_MAX;
      end else if (csr_we) begin
         case (csr_index)
            wsb_pkg::CSR_ENABLE:        cfg_ff.enable        <= csr_wdata[0];
            wsb_pkg::CSR_PERIOD_TICKS:  cfg_ff.period_ticks  <= csr_wdata;
            wsb_pkg::CSR_WIDTH_INITIAL: cfg_ff.width_initial <= csr_wdata;
            wsb_pkg::CSR_WIDTH_MIN:     cfg_ff.width_min     <= csr_wdata;
            wsb_pkg::CSR_WIDTH_MAX:     cfg_ff.width_max     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/wsb_period_calc.sv =====
// wsb_period_calc: wheel period from two capture marks, modulo 2^32
`timescale 1ns / 1ps

module wsb_period_calc (
   input  logic [31:0] period_index,
   input  logic [15:0] timer_value,
   input  logic [31:0] start_index,
   input  logic [15:0] start_timer,
   input  logic [15:0] period_ticks,
   output logic [31:0] period,
   output logic        forward
);

   logic [31:0] index_diff;
   logic [31:0] product;

   assign forward    = (period_index >= start_index);
   assign index_diff = period_index - start_index;
   assign product    = index_diff * {16'd0, period_ticks};
   assign period     = product + {16'd0, timer_value} - {16'd0, start_timer};

endmodule

// ===== rtl/wsb_width_adjust.sv =====
// wsb_width_adjust: bounded raise by two or lower by one of one pulse width
`timescale 1ns / 1ps

module wsb_width_adjust (
   input  wsb_pkg::adj_op_type op,
   input  logic [15:0]         width,
   input  logic [15:0]         width_min,
   input  logic [15:0]         width_max,
   output logic [15:0]         width_next
);

   logic [16:0] raised;
   logic [16:0] floor_limit;

   assign raised      = {1'b0, width} + 17'd2;
   assign floor_limit = {1'b0, width_min} + 17'd1;

   always_comb begin
      width_next = width;
      case (op)
         wsb_pkg::ADJ_RAISE: begin
            if (raised < {1'b0, width_max}) width_next = raised[15:0];
         end
         wsb_pkg::ADJ_LOWER: begin
            if ({1'b0, width} > floor_limit) width_next = width - 16'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== tb/wheel_speed_balancer_test.sv =====
// wheel_speed_balancer_test: self-checking testbench with a queue-fed driver and a clocked monitor
`timescale 1ns / 1ps

module wheel_speed_balancer_test;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_IDLE      = 4;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int WHEEL_R       = 0;
   localparam int WHEEL_L       = 1;

   // the one command code the block leaves unused
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef enum logic [1:0] {
      STEP_ITEM  = 2'd0,
      STEP_CSR   = 2'd1,
      STEP_DRAIN = 2'd2
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      wsb_pkg::req_item_type item;
      logic [2:0]            index;
      logic [15:0]           value;
      logic [2:0]            gap;
   } script_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   wsb_pkg::req_item_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   wsb_pkg::rsp_item_type rsp_data;
   logic                  csr_we = 1'b0;
   logic [2:0]            csr_index = wsb_pkg::CSR_ENABLE;
   logic [15:0]           csr_wdata = '0;

   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   script_step_type       edge_script[$];
   wsb_pkg::rsp_item_type expected_status[$];

   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int          hold_left = 0;
   int          rsp_hold = 0;
   int          quiet_cycles = 0;
   logic        req_calm = 1'b0;
   logic        rsp_calm = 1'b0;
   logic [31:0] edge_base [2] = '{32'd0, 32'd0};

   // balancer mirror
   wsb_pkg::cfg_type csr_mirror = '{enable: wsb_pkg::RST_ENABLE,
                                    period_ticks: wsb_pkg::RST_PERIOD_TICKS,
                                    width_initial: wsb_pkg::RST_WIDTH_INITIAL,
                                    width_min: wsb_pkg::RST_WIDTH_MIN,
                                    width_max: wsb_pkg::RST_WIDTH_MAX};
   logic        phase_odd   [2] = '{1'b0, 1'b0};
   logic        need_open   [2] = '{1'b1, 1'b1};
   logic [31:0] open_index  [2] = '{32'd0, 32'd0};
   logic [15:0] open_timer  [2] = '{16'd0, 16'd0};
   logic [31:0] wheel_period[2] = '{32'd0, 32'd0};
   logic [15:0] wheel_width [2] = '{wsb_pkg::RST_WIDTH_INITIAL, wsb_pkg::RST_WIDTH_INITIAL};

   wheel_speed_balancer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic void widen(input int w);
      logic [31:0] next;
      next = {16'd0, wheel_width[w]} + 32'd2;
      if (next < {16'd0, csr_mirror.width_max}) begin
         wheel_width[w] = next[15:0];
      end
   endfunction

   function automatic void narrow(input int w);
      if ({16'd0, wheel_width[w]} > {16'd0, csr_mirror.width_min} + 32'd1) begin
         wheel_width[w] = wheel_width[w] - 16'd1;
      end
   endfunction

   function automatic wsb_pkg::rsp_item_type balance_step(input wsb_pkg::req_item_type item);
      wsb_pkg::rsp_item_type result;
      logic [1:0]            outcome;
      logic                  closed;
      int                    w;
      int                    i;
      outcome = wsb_pkg::CORR_NONE;
      closed = 1'b0;
      w = (item.cmd == wsb_pkg::CMD_LEFT) ? WHEEL_L : WHEEL_R;
      if (item.cmd == wsb_pkg::CMD_RESTART) begin
         for (i = 0; i < 2; i++) begin
            phase_odd[i] = 1'b0;
            need_open[i] = 1'b1;
            open_index[i] = '0;
            open_timer[i] = '0;
            wheel_width[i] = csr_mirror.width_initial;
         end
      end else if ((item.cmd == wsb_pkg::CMD_RIGHT || item.cmd == wsb_pkg::CMD_LEFT)
                   && csr_mirror.enable) begin
         if (phase_odd[w]) begin
            phase_odd[w] = 1'b0;
         end else begin
            phase_odd[w] = 1'b1;
            if (need_open[w]) begin
               open_index[w] = item.period_index;
               open_timer[w] = item.timer_value;
               need_open[w] = 1'b0;
            end else begin
               need_open[w] = 1'b1;
               closed = 1'b1;
               // a backwards index keeps the old period
               if (item.period_index >= open_index[w]) begin
                  wheel_period[w] = (item.period_index - open_index[w])
                                    * {16'd0, csr_mirror.period_ticks}
                                    + {16'd0, item.timer_value} - {16'd0, open_timer[w]};
               end
            end
         end
         if (closed && item.cmd == wsb_pkg::CMD_LEFT) begin
            if (wheel_period[WHEEL_L] > wheel_period[WHEEL_R]) begin
               widen(WHEEL_L);
               narrow(WHEEL_R);
               outcome = wsb_pkg::CORR_LEFT_UP;
            end else if (wheel_period[WHEEL_L] < wheel_period[WHEEL_R]) begin
               widen(WHEEL_R);
               narrow(WHEEL_L);
               outcome = wsb_pkg::CORR_RIGHT_UP;
            end
         end
      end
      result.right_width = wheel_width[WHEEL_R];
      result.left_width = wheel_width[WHEEL_L];
      result.right_period = wheel_period[WHEEL_R];
      result.left_period = wheel_period[WHEEL_L];
      result.correction = outcome;
      return result;
   endfunction

   task automatic add_edge(input logic [1:0] cmd, input logic [31:0] idx, input logic [15:0] tmr);
      script_step_type step;
      step = '0;
      step.kind = STEP_ITEM;
      step.item.cmd = cmd;
      step.item.period_index = idx;
      step.item.timer_value = tmr;
      if ($urandom_range(0, 29) == 0) begin
         req_calm = !req_calm;
      end
      step.gap = req_calm ? 3'd0 : 3'($urandom_range(0, MAX_IDLE));
      edge_script.push_back(step);
   endtask

   task automatic add_drain();
      script_step_type step;
      step = '0;
      step.kind = STEP_DRAIN;
      edge_script.push_back(step);
   endtask

   task automatic add_write(input logic [2:0] index, input logic [15:0] value);
      script_step_type step;
      step = '0;
      step.kind = STEP_CSR;
      step.index = index;
      step.value = value;
      edge_script.push_back(step);
   endtask

   task automatic add_settings(input logic enable, input logic [15:0] ticks,
                               input logic [15:0] init, input logic [15:0] low,
                               input logic [15:0] high);
      add_drain();
      add_write(wsb_pkg::CSR_ENABLE, {15'd0, enable});
      add_write(wsb_pkg::CSR_PERIOD_TICKS, ticks);
      add_write(wsb_pkg::CSR_WIDTH_INITIAL, init);
      add_write(wsb_pkg::CSR_WIDTH_MIN, low);
      add_write(wsb_pkg::CSR_WIDTH_MAX, high);
      add_edge(wsb_pkg::CMD_RESTART, $urandom(), 16'($urandom()));
   endtask

   // mostly wheel edges near a running index so measurements close, with rare jumps
   task automatic add_random_run(input int count);
      int          n;
      int          roll;
      int          w;
      logic [1:0]  cmd;
      logic [15:0] tmr;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            add_edge(wsb_pkg::CMD_RESTART, $urandom(), 16'($urandom()));
         end else if (roll < 6) begin
            add_edge(CMD_SPARE, $urandom(), 16'($urandom()));
         end else begin
            cmd = ($urandom_range(0, 1) == 1) ? wsb_pkg::CMD_LEFT : wsb_pkg::CMD_RIGHT;
            w = (cmd == wsb_pkg::CMD_LEFT) ? WHEEL_L : WHEEL_R;
            edge_base[w] = edge_base[w] + 32'($urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0) begin
               edge_base[w] = $urandom();
            end
            case ($urandom_range(0, 7))
               0: tmr = 16'd0;
               1: tmr = 16'hFFFF;
               default: tmr = 16'($urandom());
            endcase
            add_edge(cmd, edge_base[w], tmr);
         end
         if ($urandom_range(0, 99) == 0) begin
            add_drain();
         end
      end
   endtask

   // driver
   always @(negedge clock) begin
      script_step_type step;
      logic            next_valid;
      logic            next_we;
      next_valid = req_valid;
      next_we = 1'b0;
      if (!reset) begin
         if (req_valid && req_fired) begin
            next_valid = 1'b0;
         end
         if (rsp_fired) begin
            if ($urandom_range(0, 39) == 0) begin
               rsp_calm = !rsp_calm;
            end
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
         if (!next_valid) begin
            if (hold_left > 0) begin
               hold_left--;
            end else if (edge_script.size() != 0) begin
               step = edge_script[0];
               case (step.kind)
                  STEP_ITEM: begin
                     req_data <= step.item;
                     next_valid = 1'b1;
                     hold_left = int'(step.gap);
                     void'(edge_script.pop_front());
                  end
                  STEP_CSR: begin
                     csr_index <= step.index;
                     csr_wdata <= step.value;
                     next_we = 1'b1;
                     void'(edge_script.pop_front());
                  end
                  default: begin
                     if (expected_status.size() == 0) begin
                        quiet_cycles++;
                     end else begin
                        quiet_cycles = 0;
                     end
                     if (quiet_cycles >= SETTLE_CYCLES) begin
                        quiet_cycles = 0;
                        void'(edge_script.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      req_valid <= next_valid;
      csr_we <= next_we;
   end

   // monitor and checker
   always @(posedge clock) begin
      wsb_pkg::rsp_item_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         req_fired <= req_valid && req_ready && !reset;
         rsp_fired <= rsp_valid && rsp_ready && !reset;
         if (!reset) begin
            if (rsp_valid && rsp_ready) begin
               if (expected_status.size() == 0) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("unexpected transfer: rw=%0d lw=%0d rp=%0d lp=%0d corr=%0d",
                              rsp_data.right_width, rsp_data.left_width,
                              rsp_data.right_period, rsp_data.left_period,
                              rsp_data.correction);
                  end
               end else begin
                  want = expected_status.pop_front();
                  if (rsp_data.right_width !== want.right_width
                      || rsp_data.left_width !== want.left_width
                      || rsp_data.right_period !== want.right_period
                      || rsp_data.left_period !== want.left_period
                      || rsp_data.correction !== want.correction) begin
                     fail_count++;
                     if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: want rw=%0d lw=%0d rp=%0d lp=%0d corr=%0d",
                                 want.right_width, want.left_width, want.right_period,
                                 want.left_period, want.correction);
                        $display("          got  rw=%0d lw=%0d rp=%0d lp=%0d corr=%0d",
                                 rsp_data.right_width, rsp_data.left_width,
                                 rsp_data.right_period, rsp_data.left_period,
                                 rsp_data.correction);
                     end
                  end
               end
            end
            if (req_valid && req_ready) begin
               expected_status.push_back(balance_step(req_data));
            end
            if (csr_we) begin
               case (csr_index)
                  wsb_pkg::CSR_ENABLE:        csr_mirror.enable = csr_wdata[0];
                  wsb_pkg::CSR_PERIOD_TICKS:  csr_mirror.period_ticks = csr_wdata;
                  wsb_pkg::CSR_WIDTH_INITIAL: csr_mirror.width_initial = csr_wdata;
                  wsb_pkg::CSR_WIDTH_MIN:     csr_mirror.width_min = csr_wdata;
                  wsb_pkg::CSR_WIDTH_MAX:     csr_mirror.width_max = csr_wdata;
                  default: ;
               endcase
            end
         end
      end
   end

   initial begin
      logic [15:0] init;

      // unused command at both extremes
      add_edge(CMD_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
      add_edge(CMD_SPARE, 32'd0, 16'd0);
      // right: open, skip, close, skip
      add_edge(wsb_pkg::CMD_RIGHT, 32'd10, 16'd100);
      add_edge(wsb_pkg::CMD_RIGHT, 32'd11, 16'd7);
      add_edge(wsb_pkg::CMD_RIGHT, 32'd12, 16'd50);
      add_edge(wsb_pkg::CMD_RIGHT, 32'd0, 16'd0);
      // left slower, left sped up
      add_edge(wsb_pkg::CMD_LEFT, 32'd0, 16'd0);
      add_edge(wsb_pkg::CMD_LEFT, 32'd0, 16'd5);
      add_edge(wsb_pkg::CMD_LEFT, 32'd1, 16'hFFFF);
      add_edge(wsb_pkg::CMD_LEFT, 32'd3, 16'd3);
      // backwards index keeps the left period, still compared
      add_edge(wsb_pkg::CMD_LEFT, 32'hFFFF_FFFF, 16'd0);
      add_edge(wsb_pkg::CMD_LEFT, 32'd0, 16'd0);
      add_edge(wsb_pkg::CMD_LEFT, 32'd5, 16'd10);
      add_edge(wsb_pkg::CMD_LEFT, 32'd6, 16'd0);
      add_edge(wsb_pkg::CMD_RESTART, 32'd0, 16'd0);
      // equal periods
      add_edge(wsb_pkg::CMD_LEFT, 32'd10, 16'd100);
      add_edge(wsb_pkg::CMD_LEFT, 32'd11, 16'd0);
      add_edge(wsb_pkg::CMD_LEFT, 32'd12, 16'd50);
      add_edge(wsb_pkg::CMD_LEFT, 32'd12, 16'd0);
      // timer lower at the same index wraps the period
      add_edge(wsb_pkg::CMD_LEFT, 32'd7, 16'd500);
      add_edge(wsb_pkg::CMD_LEFT, 32'd7, 16'd0);
      add_edge(wsb_pkg::CMD_LEFT, 32'd7, 16'd100);
      add_edge(wsb_pkg::CMD_LEFT, 32'd8, 16'd0);
      // disabled: edges ignored, restart still acts
      add_drain();
      add_write(wsb_pkg::CSR_ENABLE, 16'd0);
      add_edge(wsb_pkg::CMD_RIGHT, 32'd20, 16'd20);
      add_edge(wsb_pkg::CMD_RESTART, 32'd0, 16'd0);
      add_edge(wsb_pkg::CMD_LEFT, 32'd21, 16'd21);

      add_settings(1'b1, 16'd999, 16'd750, 16'd700, 16'd850);
      add_random_run(150);
      add_settings(1'b1, 16'd1, 16'd0, 16'd0, 16'hFFFF);
      add_random_run(120);
      add_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_random_run(60);
      add_settings(1'b1, 16'($urandom_range(1, 65535)), 16'd100, 16'd98, 16'd104);
      add_random_run(150);
      add_settings(1'b0, 16'd12345, 16'd500, 16'd0, 16'd0);
      add_random_run(30);
      init = 16'($urandom_range(10, 65525));
      add_settings(1'b1, 16'($urandom_range(1, 65535)), init,
                   init - 16'($urandom_range(0, 8)), init + 16'($urandom_range(0, 8)));
      add_random_run(140);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while (edge_script.size() != 0 || req_valid || expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wsb_pkg.sv
rtl/wsb_csr.sv
rtl/wsb_period_calc.sv
rtl/wsb_width_adjust.sv
rtl/wheel_speed_balancer.sv
tb/wheel_speed_balancer_test.sv
